// ===== rtl/selection_shape_hit_test_unit_defines.svh =====
// -----------------------------------------------------------------------------
// Selection shape hit test: assertion macros
// Concurrent check wrappers; they compile away when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef SELECTION_SHAPE_HIT_TEST_UNIT_DEFINES_SVH
`define SELECTION_SHAPE_HIT_TEST_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SSHT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSHT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `SSHT_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define SSHT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSHT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/ssht_pkg.sv =====
// -----------------------------------------------------------------------------
// Selection shape hit test package
// Operation, shape and register codes, defaults and the cell control bundle.
// -----------------------------------------------------------------------------
package ssht_pkg;

  localparam int MAX_POLY_VERTICES_DEF = 256;
  localparam int COORD_BITS_DEF        = 16;
  localparam int APB_ADDR_W            = 5;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEST   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_BOX    = 2'd0,
    MODE_CIRCLE = 2'd1,
    MODE_LASSO  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_SHAPE_MODE = 3'd0,
    REG_START_X    = 3'd1,
    REG_START_Y    = 3'd2,
    REG_END_X      = 3'd3,
    REG_END_Y      = 3'd4
  } reg_idx_e;

  // control bits that travel with a point through the edge cells
  typedef struct packed {
    logic valid;
    logic kill;
    logic par;
    logic hit;
    logic dpos;
  } cell_ctl_t;

endpackage

// ===== rtl/ssht_edge_cell.sv =====
// -----------------------------------------------------------------------------
// Edge cell
// Holds one lasso vertex, resolves the crossing of the previous cell's edge
// and forms the cross products of its own edge for the next cell.
// -----------------------------------------------------------------------------
module ssht_edge_cell
  import ssht_pkg::*;
#(
  parameter int COORD_BITS        = COORD_BITS_DEF,
  parameter int MAX_POLY_VERTICES = MAX_POLY_VERTICES_DEF,
  parameter int IDX               = 0,
  localparam int CNT_W            = $clog2(MAX_POLY_VERTICES + 1),
  localparam int IDX_W            = $clog2(MAX_POLY_VERTICES),
  localparam int PROD_W           = 2 * COORD_BITS + 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic [CNT_W-1:0]             vcnt_i,
  input  logic                         wr_en_i,
  input  logic [IDX_W-1:0]             wr_idx_i,
  input  logic signed [COORD_BITS-1:0] wr_x_i,
  input  logic signed [COORD_BITS-1:0] wr_y_i,
  input  logic signed [COORD_BITS-1:0] nb_x_i,
  input  logic signed [COORD_BITS-1:0] nb_y_i,
  output logic signed [COORD_BITS-1:0] vx_o,
  output logic signed [COORD_BITS-1:0] vy_o,
  input  cell_ctl_t                    ctl_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  input  logic signed [PROD_W-1:0]     lhs_i,
  input  logic signed [PROD_W-1:0]     rhs_i,
  output cell_ctl_t                    ctl_o,
  output logic signed [COORD_BITS-1:0] x_o,
  output logic signed [COORD_BITS-1:0] y_o,
  output logic signed [PROD_W-1:0]     lhs_o,
  output logic signed [PROD_W-1:0]     rhs_o
);

  logic signed [COORD_BITS-1:0] vx_q, vy_q;
  logic signed [COORD_BITS:0]   y_ay, x_ax, bx_ax, by_ay;
  logic signed [PROD_W-1:0]     lhs_d, rhs_d, lhs_q, rhs_q;
  logic signed [COORD_BITS-1:0] x_q, y_q;
  logic                         left, straddle, active;
  cell_ctl_t                    ctl_d, ctl_q;

  // edge runs from this vertex (a) to the neighbor's vertex (b)
  assign active   = vcnt_i > CNT_W'(IDX);
  assign straddle = ((vy_q < y_i) && (nb_y_i >= y_i)) || ((nb_y_i < y_i) && (vy_q >= y_i));

  assign y_ay  = $signed({y_i[COORD_BITS-1], y_i}) - $signed({vy_q[COORD_BITS-1], vy_q});
  assign x_ax  = $signed({x_i[COORD_BITS-1], x_i}) - $signed({vx_q[COORD_BITS-1], vx_q});
  assign bx_ax = $signed({nb_x_i[COORD_BITS-1], nb_x_i}) - $signed({vx_q[COORD_BITS-1], vx_q});
  assign by_ay = $signed({nb_y_i[COORD_BITS-1], nb_y_i}) - $signed({vy_q[COORD_BITS-1], vy_q});

  assign lhs_d = y_ay * bx_ax;
  assign rhs_d = x_ax * by_ay;

  // settle the crossing handed over by the previous cell
  assign left = ctl_i.dpos ? (lhs_i < rhs_i) : (lhs_i > rhs_i);

  always_comb begin
    ctl_d       = ctl_i;
    ctl_d.par   = ctl_i.par ^ (ctl_i.hit & left);
    ctl_d.hit   = active & straddle;
    ctl_d.dpos  = vy_q < y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
    end
    if (wr_en_i && (wr_idx_i == IDX_W'(IDX))) begin
      vx_q <= wr_x_i;
      vy_q <= wr_y_i;
    end
  end

  assign vx_o  = vx_q;
  assign vy_o  = vy_q;
  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign lhs_o = lhs_q;
  assign rhs_o = rhs_q;

endmodule

// ===== rtl/ssht_shape_tail.sv =====
// -----------------------------------------------------------------------------
// Shape tail
// Closes the last lasso crossing, tests box and circle, picks the result
// by shape mode.
// -----------------------------------------------------------------------------
module ssht_shape_tail
  import ssht_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int PROD_W    = 2 * COORD_BITS + 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic [1:0]                   mode_i,
  input  logic signed [COORD_BITS-1:0] sx_i,
  input  logic signed [COORD_BITS-1:0] sy_i,
  input  logic signed [COORD_BITS-1:0] ex_i,
  input  logic signed [COORD_BITS-1:0] ey_i,
  input  cell_ctl_t                    ctl_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  input  logic signed [PROD_W-1:0]     lhs_i,
  input  logic signed [PROD_W-1:0]     rhs_i,
  output logic                         res_valid_o,
  output logic                         res_inside_o
);

  logic signed [COORD_BITS:0]   dx, dy, rdx, rdy;
  logic [COORD_BITS-1:0]        rax, ray, r_q;
  logic [2*COORD_BITS-1:0]      r2_q;
  logic signed [PROD_W-1:0]     dx2_full, dy2_full;
  logic [2*COORD_BITS:0]        dx2_q, dy2_q;
  logic [2*COORD_BITS+1:0]      dist2;
  logic                         left, box_d;
  logic                         valid_q, kill_q, par_q, box_q;

  assign left = ctl_i.dpos ? (lhs_i < rhs_i) : (lhs_i > rhs_i);

  assign box_d = ((x_i >= sx_i && x_i <= ex_i) || (x_i >= ex_i && x_i <= sx_i)) &&
                 ((y_i >= sy_i && y_i <= ey_i) || (y_i >= ey_i && y_i <= sy_i));

  assign dx = $signed({x_i[COORD_BITS-1], x_i}) - $signed({sx_i[COORD_BITS-1], sx_i});
  assign dy = $signed({y_i[COORD_BITS-1], y_i}) - $signed({sy_i[COORD_BITS-1], sy_i});
  assign dx2_full = dx * dx;
  assign dy2_full = dy * dy;

  // radius follows the registers through r_q and then r2_q after a write
  assign rdx = $signed({ex_i[COORD_BITS-1], ex_i}) - $signed({sx_i[COORD_BITS-1], sx_i});
  assign rdy = $signed({ey_i[COORD_BITS-1], ey_i}) - $signed({sy_i[COORD_BITS-1], sy_i});
  assign rax = rdx[COORD_BITS] ? COORD_BITS'(-rdx) : rdx[COORD_BITS-1:0];
  assign ray = rdy[COORD_BITS] ? COORD_BITS'(-rdy) : rdy[COORD_BITS-1:0];

  always_ff @(posedge clk_i) begin
    r_q  <= (rax > ray) ? rax : ray;
    r2_q <= r_q * r_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      kill_q <= ctl_i.kill;
      par_q  <= ctl_i.par ^ (ctl_i.hit & left);
      box_q  <= box_d;
      dx2_q  <= dx2_full[2*COORD_BITS:0];
      dy2_q  <= dy2_full[2*COORD_BITS:0];
    end
  end

  assign dist2 = {1'b0, dx2_q} + {1'b0, dy2_q};

  always_comb begin
    case (mode_i)
      MODE_CIRCLE: res_inside_o = !kill_q && (dist2 < {2'b00, r2_q});
      MODE_LASSO:  res_inside_o = !kill_q && par_q;
      default:     res_inside_o = !kill_q && box_q;
    endcase
  end

  assign res_valid_o = valid_q;

endmodule

// ===== rtl/selection_shape_hit_test_unit.sv =====
// -----------------------------------------------------------------------------
// Selection shape hit test unit
// Path: the input stage loads a test word on the edge that takes it; the word
// then passes one edge cell per vertex slot, the tail and the output register.
// Throughput: one test word per cycle through the cell row while the result
// side accepts words; a clear or append waits until the row is empty.
// Reset: asynchronous, clears registers, vertex count and valid bits; vertex
// storage is not cleared.
// -----------------------------------------------------------------------------
`include "selection_shape_hit_test_unit_defines.svh"

module selection_shape_hit_test_unit
  import ssht_pkg::*;
#(
  parameter int COORD_BITS        = COORD_BITS_DEF,
  parameter int MAX_POLY_VERTICES = MAX_POLY_VERTICES_DEF,
  localparam int S_TDATA_W        = ((2 * COORD_BITS + 1 + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input words
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // px, py, excluded, zero pad
  input  logic [1:0]            s_axis_tuser,  // op
  // result words
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata   // inside_res, overflow, zero pad
);

  localparam int CNT_W    = $clog2(MAX_POLY_VERTICES + 1);
  localparam int IDX_W    = $clog2(MAX_POLY_VERTICES);
  localparam int PROD_W   = 2 * COORD_BITS + 2;
  localparam int FLIGHT_W = $clog2(MAX_POLY_VERTICES + 3);

  // configuration registers
  logic [1:0]                   mode_q;
  logic signed [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      sx_q   <= '0;
      sy_q   <= '0;
      ex_q   <= '0;
      ey_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[APB_ADDR_W-1:2])
        REG_SHAPE_MODE: mode_q <= pwdata[1:0];
        REG_START_X:    sx_q   <= pwdata[COORD_BITS-1:0];
        REG_START_Y:    sy_q   <= pwdata[COORD_BITS-1:0];
        REG_END_X:      ex_q   <= pwdata[COORD_BITS-1:0];
        REG_END_Y:      ey_q   <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[APB_ADDR_W-1:2])
      REG_SHAPE_MODE: prdata = {30'd0, mode_q};
      REG_START_X:    prdata = {{(32 - COORD_BITS){sx_q[COORD_BITS-1]}}, sx_q};
      REG_START_Y:    prdata = {{(32 - COORD_BITS){sy_q[COORD_BITS-1]}}, sy_q};
      REG_END_X:      prdata = {{(32 - COORD_BITS){ex_q[COORD_BITS-1]}}, ex_q};
      REG_END_Y:      prdata = {{(32 - COORD_BITS){ey_q[COORD_BITS-1]}}, ey_q};
      default:        prdata = '0;
    endcase
  end

  // input decode and handshake
  logic [1:0]                   in_op;
  logic signed [COORD_BITS-1:0] in_x, in_y;
  logic                         in_excl;
  logic                         adv, is_test, acc, test_acc, side_acc;
  logic                         app_ok, ovf_d, tail_valid, tail_inside;
  logic [FLIGHT_W-1:0]          flight_q;
  logic [CNT_W-1:0]             vcnt_q;
  logic signed [COORD_BITS-1:0] last_x_q, last_y_q;

  assign in_op   = s_axis_tuser;
  assign in_x    = s_axis_tdata[COORD_BITS-1:0];
  assign in_y    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_excl = s_axis_tdata[2*COORD_BITS];

  logic out_valid_q, out_inside_q, out_ovf_q;

  assign adv     = !out_valid_q || m_axis_tready;
  assign is_test = in_op == OP_TEST;
  // vertex edits only with the cell row empty
  assign s_axis_tready = adv && (is_test || (flight_q == '0));
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign test_acc = acc && is_test;
  assign side_acc = acc && !is_test;
  assign app_ok   = side_acc && (in_op == OP_APPEND) &&
                    (vcnt_q < CNT_W'(MAX_POLY_VERTICES));
  assign ovf_d    = side_acc && (in_op == OP_APPEND) &&
                    (vcnt_q >= CNT_W'(MAX_POLY_VERTICES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= '0;
    end else if (side_acc && (in_op == OP_CLEAR)) begin
      vcnt_q <= '0;
    end else if (app_ok) begin
      vcnt_q <= vcnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (app_ok) begin
      last_x_q <= in_x;
      last_y_q <= in_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
    end else begin
      if (test_acc && !(adv && tail_valid)) begin
        flight_q <= flight_q + FLIGHT_W'(1);
      end else if (!test_acc && adv && tail_valid) begin
        flight_q <= flight_q - FLIGHT_W'(1);
      end
    end
  end

  // input stage
  cell_ctl_t                    s0_ctl_q;
  logic signed [COORD_BITS-1:0] s0_x_q, s0_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctl_q <= '0;
    end else if (adv) begin
      s0_ctl_q <= '{valid: test_acc, kill: in_excl, par: 1'b0, hit: 1'b0, dpos: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_x_q <= in_x;
      s0_y_q <= in_y;
    end
  end

  // row of edge cells
  cell_ctl_t                    ctl_w [MAX_POLY_VERTICES+1];
  logic signed [COORD_BITS-1:0] x_w   [MAX_POLY_VERTICES+1];
  logic signed [COORD_BITS-1:0] y_w   [MAX_POLY_VERTICES+1];
  logic signed [PROD_W-1:0]     lhs_w [MAX_POLY_VERTICES+1];
  logic signed [PROD_W-1:0]     rhs_w [MAX_POLY_VERTICES+1];
  logic signed [COORD_BITS-1:0] vx_w  [MAX_POLY_VERTICES];
  logic signed [COORD_BITS-1:0] vy_w  [MAX_POLY_VERTICES];

  assign ctl_w[0] = s0_ctl_q;
  assign x_w[0]   = s0_x_q;
  assign y_w[0]   = s0_y_q;
  assign lhs_w[0] = '0;
  assign rhs_w[0] = '0;

  for (genvar g = 0; g < MAX_POLY_VERTICES; g++) begin : g_cell
    logic signed [COORD_BITS-1:0] nb_x, nb_y;

    // the first cell carries the closing edge to the last vertex
    if (g == 0) begin : g_first
      assign nb_x = last_x_q;
      assign nb_y = last_y_q;
    end else begin : g_rest
      assign nb_x = vx_w[g-1];
      assign nb_y = vy_w[g-1];
    end

    ssht_edge_cell #(
      .COORD_BITS        (COORD_BITS),
      .MAX_POLY_VERTICES (MAX_POLY_VERTICES),
      .IDX               (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .vcnt_i   (vcnt_q),
      .wr_en_i  (app_ok),
      .wr_idx_i (vcnt_q[IDX_W-1:0]),
      .wr_x_i   (in_x),
      .wr_y_i   (in_y),
      .nb_x_i   (nb_x),
      .nb_y_i   (nb_y),
      .vx_o     (vx_w[g]),
      .vy_o     (vy_w[g]),
      .ctl_i    (ctl_w[g]),
      .x_i      (x_w[g]),
      .y_i      (y_w[g]),
      .lhs_i    (lhs_w[g]),
      .rhs_i    (rhs_w[g]),
      .ctl_o    (ctl_w[g+1]),
      .x_o      (x_w[g+1]),
      .y_o      (y_w[g+1]),
      .lhs_o    (lhs_w[g+1]),
      .rhs_o    (rhs_w[g+1])
    );
  end

  ssht_shape_tail #(
    .COORD_BITS (COORD_BITS)
  ) u_tail (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .mode_i       (mode_q),
    .sx_i         (sx_q),
    .sy_i         (sy_q),
    .ex_i         (ex_q),
    .ey_i         (ey_q),
    .ctl_i        (ctl_w[MAX_POLY_VERTICES]),
    .x_i          (x_w[MAX_POLY_VERTICES]),
    .y_i          (y_w[MAX_POLY_VERTICES]),
    .lhs_i        (lhs_w[MAX_POLY_VERTICES]),
    .rhs_i        (rhs_w[MAX_POLY_VERTICES]),
    .res_valid_o  (tail_valid),
    .res_inside_o (tail_inside)
  );

  // output register; tail results and vertex edits never land together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tail_valid || side_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_inside_q <= tail_valid && tail_inside;
      out_ovf_q    <= !tail_valid && ovf_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_ovf_q, out_inside_q};

  `SSHT_ASSERT_NEVER(a_vcnt_range, clk_i, rst_ni, vcnt_q > CNT_W'(MAX_POLY_VERTICES), "vertex count past capacity")
  `SSHT_ASSERT(a_ovf_flag, clk_i, rst_ni, (side_acc && (in_op == OP_APPEND) && (vcnt_q == CNT_W'(MAX_POLY_VERTICES))) |=> (m_axis_tvalid && m_axis_tdata[1]), "dropped append not flagged")
  `SSHT_ASSERT(a_flight_track, clk_i, rst_ni, tail_valid |-> (flight_q != '0), "result leaves the row with nothing counted in flight")
  `SSHT_ASSERT_NEVER(a_res_excl, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[1], "inside and overflow set together")
  `SSHT_ASSERT(a_clear_cnt, clk_i, rst_ni, (side_acc && (in_op == OP_CLEAR)) |=> (vcnt_q == '0), "clear left vertices behind")

endmodule

// ===== tb/tb_selection_shape_hit_test_unit.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Selection shape hit test unit testbench
// Drives box, circle and lasso phases through the stream port and reprograms
// the shape registers over APB between phases. A software copy of the unit
// predicts every result word; both stream sides idle at random, and one
// phase holds the result side off long enough to back up the cell row.
// -----------------------------------------------------------------------------
module tb_selection_shape_hit_test_unit;
  import ssht_pkg::*;

  localparam int MAX_V        = MAX_POLY_VERTICES_DEF;
  localparam int LAT          = MAX_V + 3;
  localparam int ITEMS_TARGET = 700;
  localparam int HOLD_CYCLES  = 600;
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic overflow;
    logic hit;
  } hit_word_t;

  // predicts one result word per input word and checks the unit's words
  class hit_scoreboard;
    logic [1:0] shape_mode;
    shortint    sx, sy, ex, ey;
    shortint    vx[MAX_V];
    shortint    vy[MAX_V];
    int         vcount;
    hit_word_t  expected_hits[$];
    int         failures;
    int         reported;

    function new();
      shape_mode = MODE_BOX;
      sx = 0; sy = 0; ex = 0; ey = 0;
      vcount = 0;
      failures = 0;
      reported = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] v);
      case (idx)
        REG_SHAPE_MODE: shape_mode = v[1:0];
        REG_START_X:    sx = shortint'(v[15:0]);
        REG_START_Y:    sy = shortint'(v[15:0]);
        REG_END_X:      ex = shortint'(v[15:0]);
        REG_END_Y:      ey = shortint'(v[15:0]);
        default: ;
      endcase
    endfunction

    function bit in_box(longint x, longint y);
      longint lx, hx, ly, hy;
      lx = (sx < ex) ? sx : ex;
      hx = (sx < ex) ? ex : sx;
      ly = (sy < ey) ? sy : ey;
      hy = (sy < ey) ? ey : sy;
      return x >= lx && x <= hx && y >= ly && y <= hy;
    endfunction

    function bit in_circle(longint x, longint y);
      longint ax, ay, r, dx, dy;
      ax = longint'(ex) - longint'(sx);
      ay = longint'(ey) - longint'(sy);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      r  = (ax > ay) ? ax : ay;
      dx = x - sx;
      dy = y - sy;
      return dx * dx + dy * dy < r * r;
    endfunction

    // even-odd crossing, cross-multiplied so no division is needed
    function bit in_lasso(longint x, longint y);
      bit odd;
      int j;
      longint ax, ay, bx, by, d, lhs, rhs;
      odd = 1'b0;
      if (vcount == 0) return 1'b0;
      j = vcount - 1;
      for (int i = 0; i < vcount; i++) begin
        ax = vx[i]; ay = vy[i];
        bx = vx[j]; by = vy[j];
        if ((ay < y && by >= y) || (by < y && ay >= y)) begin
          d   = by - ay;
          lhs = (y - ay) * (bx - ax);
          rhs = (x - ax) * d;
          if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) odd = ~odd;
        end
        j = i;
      end
      return odd;
    endfunction

    function void note_word(logic [1:0] op, shortint x, shortint y, logic excl);
      hit_word_t w;
      w = '0;
      case (op)
        OP_CLEAR: vcount = 0;
        OP_APPEND: begin
          if (vcount < MAX_V) begin
            vx[vcount] = x;
            vy[vcount] = y;
            vcount++;
          end else begin
            w.overflow = 1'b1;
          end
        end
        OP_TEST: begin
          if (!excl) begin
            if (shape_mode == MODE_CIRCLE) w.hit = in_circle(x, y);
            else if (shape_mode == MODE_LASSO) w.hit = in_lasso(x, y);
            else w.hit = in_box(x, y);
          end
        end
        default: ;
      endcase
      expected_hits = {expected_hits, w};
    endfunction

    function void check_word(logic [7:0] data);
      hit_word_t want;
      if (expected_hits.size() == 0) begin
        failures++;
        if (reported < 10) $display("unexpected result word %02h", data);
        reported++;
        return;
      end
      want = expected_hits.pop_front();
      if (data[0] !== want.hit || data[1] !== want.overflow) begin
        failures++;
        if (reported < 10)
          $display("mismatch at %0t: inside exp %0b got %0b, overflow exp %0b got %0b",
                   $realtime, want.hit, data[0], want.overflow, data[1]);
        reported++;
      end
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [39:0]           s_axis_tdata;  // px, py, excluded, zero pad
  logic [1:0]            s_axis_tuser;  // op
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;  // inside_res, overflow, zero pad

  logic calm;
  logic hold_req;
  logic holding;
  int   words_sent;

  hit_scoreboard sb = new();

  selection_shape_hit_test_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin : run_limit
    #2000000;
    $display("selection_shape_hit_test_unit regression: fail");
    $finish;
  end

  // result side: random back-pressure, held off completely while holding
  initial begin : result_ready
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = !holding && (calm || $urandom_range(99) >= 37);
    end
  end

  initial begin : result_hold
    holding = 1'b0;
    wait (hold_req);
    @(posedge clk_i);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    holding = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
  end

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = APB_ADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // reprogram the shape once the unit has gone quiet
  task automatic set_shape(logic [1:0] mode, shortint x0, shortint y0,
                           shortint x1, shortint y1);
    drain();
    apb_write(REG_SHAPE_MODE, {30'd0, mode});
    apb_write(REG_START_X, 32'(int'(x0)));
    apb_write(REG_START_Y, 32'(int'(y0)));
    apb_write(REG_END_X, 32'(int'(x1)));
    apb_write(REG_END_Y, 32'(int'(y1)));
  endtask

  // entered at a falling edge; leaves tvalid high after the handshake
  task automatic send_word(logic [1:0] op, shortint x, shortint y, logic excl);
    while (!calm && $urandom_range(99) < 37) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {7'd0, excl, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(op, x, y, excl);
    words_sent++;
    @(negedge clk_i);
  endtask

  function automatic shortint near_coord(shortint c, int span);
    if ($urandom_range(0, 6) == 0) return shortint'($urandom);
    return shortint'(int'(c) + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  initial begin : stimulus
    logic [1:0] mode;
    shortint    cx, cy, vxl, vyl, tx, ty;
    shortint    lx[$];
    shortint    ly[$];
    int         span, nverts, ntests, r;
    bit         hold_phase, fill_phase;

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_CLEAR;
    calm          = 1'b0;
    hold_req      = 1'b0;
    words_sent    = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset shape: a one-point box at the origin
    send_word(OP_TEST, 0, 0, 1'b0);
    send_word(OP_TEST, 1, 0, 1'b0);
    send_word(OP_TEST, 0, -1, 1'b0);
    send_word(OP_TEST, 0, 0, 1'b1);
    send_word(OP_UNUSED, 0, 0, 1'b1);

    // full-range box with swapped corners
    set_shape(MODE_BOX, 32767, 32767, -32768, -32768);
    send_word(OP_TEST, -32768, -32768, 1'b0);
    send_word(OP_TEST, 32767, 32767, 1'b0);
    send_word(OP_TEST, -32768, 32767, 1'b0);
    send_word(OP_TEST, 32767, -32768, 1'b1);

    // largest circle; first point sits exactly on the rim
    set_shape(MODE_CIRCLE, -32768, -32768, 32767, 0);
    send_word(OP_TEST, 32767, -32768, 1'b0);
    send_word(OP_TEST, -32768, 32766, 1'b0);
    send_word(OP_TEST, 0, 0, 1'b0);
    send_word(OP_TEST, 32767, 32767, 1'b0);

    // lasso: empty, two vertices, triangle with a horizontal edge, cleared
    set_shape(MODE_LASSO, 0, 0, 0, 0);
    send_word(OP_TEST, 5, 5, 1'b0);
    send_word(OP_APPEND, 0, 0, 1'b0);
    send_word(OP_APPEND, 100, 0, 1'b0);
    send_word(OP_TEST, 10, 0, 1'b0);
    send_word(OP_APPEND, 0, 100, 1'b0);
    send_word(OP_TEST, 10, 10, 1'b0);
    send_word(OP_TEST, 100, 100, 1'b0);
    send_word(OP_TEST, 50, 0, 1'b0);
    send_word(OP_TEST, -1, 50, 1'b0);
    send_word(OP_CLEAR, 0, 0, 1'b0);
    send_word(OP_TEST, 10, 10, 1'b0);

    // unused mode falls back to the box
    set_shape(MODE_UNUSED, -10, -10, 10, 10);
    send_word(OP_TEST, 0, 0, 1'b0);

    for (int ph = 0; words_sent < ITEMS_TARGET; ph++) begin
      hold_phase = (ph == 2);
      fill_phase = (ph == 4);
      mode = (hold_phase || fill_phase) ? MODE_LASSO : 2'($urandom_range(0, 3));
      cx   = shortint'($urandom);
      cy   = shortint'($urandom);
      span = ($urandom_range(0, 3) == 0) ? 20000 : $urandom_range(4, 300);
      set_shape(mode, cx, cy, near_coord(cx, span), near_coord(cy, span));

      lx.delete();
      ly.delete();
      if (mode == MODE_LASSO) begin
        send_word(OP_CLEAR, 0, 0, 1'b0);
        if (fill_phase) nverts = MAX_V + 3;
        else if ($urandom_range(0, 9) == 0) nverts = $urandom_range(0, 2);
        else nverts = $urandom_range(3, 14);
        for (int v = 0; v < nverts; v++) begin
          vxl = near_coord(cx, span);
          // repeat the previous y now and then to get horizontal edges
          vyl = (v > 0 && $urandom_range(0, 3) == 0) ? ly[$] : near_coord(cy, span);
          lx = {lx, vxl};
          ly = {ly, vyl};
          send_word(OP_APPEND, vxl, vyl, 1'b0);
        end
      end

      ntests = hold_phase ? 300 : (fill_phase ? 30 : $urandom_range(40, 80));
      if (hold_phase) begin
        calm     = 1'b1;
        hold_req = 1'b1;
      end
      for (int t = 0; t < ntests; t++) begin
        r = $urandom_range(0, 99);
        if (!hold_phase && r < 3) begin
          send_word(OP_UNUSED, shortint'($urandom), shortint'($urandom), 1'($urandom));
        end else if (!hold_phase && r < 5) begin
          send_word(OP_APPEND, near_coord(cx, span), near_coord(cy, span), 1'($urandom));
        end else if (!hold_phase && r == 5) begin
          send_word(OP_CLEAR, shortint'($urandom), shortint'($urandom), 1'($urandom));
        end else begin
          tx = near_coord(cx, span + span / 2);
          ty = near_coord(cy, span + span / 2);
          // land on vertex coordinates or a corner to probe the boundaries
          if (r >= 92 && lx.size() != 0) begin
            tx = lx[$urandom_range(0, lx.size() - 1)];
            ty = ly[$urandom_range(0, ly.size() - 1)];
          end else if (r >= 92) begin
            tx = sb.ex;
            ty = ($urandom_range(0, 1) == 0) ? sb.ey : sb.sy;
          end
          send_word(OP_TEST, tx, ty, $urandom_range(0, 7) == 0);
        end
      end
      calm = 1'b0;
    end

    drain();
    repeat (LAT + 20) @(negedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("selection_shape_hit_test_unit regression: pass");
    end else begin
      $display("selection_shape_hit_test_unit regression: fail");
    end
    $finish;
  end

endmodule
